/* rtl/rast_pkg.sv */
package rast_pkg;

    localparam int MAX_LEAVES = 65536;
    localparam int NODE_DEPTH = 2 * MAX_LEAVES;
    localparam int ADDR_W     = $clog2(NODE_DEPTH);
    localparam int POS_W      = 17;
    localparam int SUM_W      = 64;
    localparam int VAL_W      = 32;
    localparam int STK_DEPTH  = 32;
    localparam int SP_W       = $clog2(STK_DEPTH);

    // request kinds carried on tuser
    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_SUM = 1'b1;

    typedef struct packed {
        logic             is_query;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic [POS_W-1:0] n;
        logic [SUM_W-1:0] val;
    } req_t;

    typedef struct packed {
        logic ready;
        logic done;
    } ctrl_stat_t;

endpackage

/* rtl/range_add_range_sum_tree.sv */
// channel  | ports                         | contents
// s (in)   | s_tvalid s_tready s_tdata/user| tdata: left_index, right_index, add_value
//          |                               | tuser: req_type
// m (out)  | m_tvalid m_tready m_tdata     | tdata: range_sum
// cfg      | cfg_wen cfg_wdata             | active_length
//
// after reset a clearing pass writes all 131072 nodes, one per cycle, before s_tready rises
// each request walks the tree on the two node memories, each with one read and one write port:
// a covered node is summed or updated in place, a partly covered node first pushes any pending
// add to both children, and s_tready stays low until the word is finished
// a finished sum waits in the output register while the next word is walked
// a query result that cannot leave holds the walker until m_tready frees the register
module range_add_range_sum_tree (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [16:0] cfg_wdata,    // active_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,      // left_index, right_index, add_value, zero pad
    input  logic        s_tuser,      // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata       // range_sum
);

    localparam int PW = rast_pkg::POS_W;
    localparam int SW = rast_pkg::SUM_W;
    localparam int VW = rast_pkg::VAL_W;
    localparam logic [PW-1:0] MAX_N = PW'(rast_pkg::MAX_LEAVES);

    logic [PW-1:0]        active_length_reg;
    logic                 m_tvalid_reg;
    logic [SW-1:0]        m_tdata_reg;
    logic [PW-1:0]        left_index;
    logic [PW-1:0]        right_index;
    logic [VW-1:0]        add_value;
    logic [PW-1:0]        n_clip;
    rast_pkg::req_t       req;
    rast_pkg::ctrl_stat_t stat;
    logic [SW-1:0]        result;
    logic                 out_free;
    logic                 start;

    assign left_index  = s_tdata[16:0];
    assign right_index = s_tdata[33:17];
    assign add_value   = s_tdata[65:34];

    assign n_clip = (active_length_reg == '0) ? PW'(1) :
                    (active_length_reg > MAX_N) ? MAX_N : active_length_reg;

    assign req.is_query = s_tuser;
    assign req.n        = n_clip;
    assign req.lo       = (left_index == '0) ? PW'(1) : left_index;
    assign req.hi       = (right_index > n_clip) ? n_clip : right_index;
    assign req.val      = {{(SW-VW){add_value[VW-1]}}, add_value};

    assign s_tready = stat.ready;
    assign start    = s_tvalid && stat.ready;
    assign out_free = !m_tvalid_reg || m_tready;

    rast_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .req      (req),
        .out_free (out_free),
        .stat     (stat),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_length_reg <= MAX_N;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wen) begin
                active_length_reg <= cfg_wdata;
            end
            if (stat.done) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= result;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/rast_ram.sv */
module rast_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/rast_ctrl.sv */
module rast_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  rast_pkg::req_t                req,
    input  logic                          out_free,
    output rast_pkg::ctrl_stat_t          stat,
    output logic [rast_pkg::SUM_W-1:0]    result
);

    localparam int AW  = rast_pkg::ADDR_W;
    localparam int PW  = rast_pkg::POS_W;
    localparam int SW  = rast_pkg::SUM_W;
    localparam int VW  = rast_pkg::VAL_W;
    localparam int SPW = rast_pkg::SP_W;

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_ENTER  = 5'd2;
    localparam logic [4:0] S_Q_ACC  = 5'd3;
    localparam logic [4:0] S_P_CHK  = 5'd4;
    localparam logic [4:0] S_P_R    = 5'd5;
    localparam logic [4:0] S_P_CLR  = 5'd6;
    localparam logic [4:0] S_NA_RD  = 5'd7;
    localparam logic [4:0] S_NA_M0  = 5'd8;
    localparam logic [4:0] S_NA_M1  = 5'd9;
    localparam logic [4:0] S_NA_WR  = 5'd10;
    localparam logic [4:0] S_DESC_L = 5'd11;
    localparam logic [4:0] S_DESC_R = 5'd12;
    localparam logic [4:0] S_FIX    = 5'd13;
    localparam logic [4:0] S_F_RD1  = 5'd14;
    localparam logic [4:0] S_F_WR   = 5'd15;
    localparam logic [4:0] S_RET    = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;

    localparam logic PH_LEFT  = 1'b0;
    localparam logic PH_RIGHT = 1'b1;

    logic [4:0]     state_reg;
    logic [AW-1:0]  clr_cnt_reg;
    logic [SPW-1:0] sp_reg;
    rast_pkg::req_t req_reg;

    logic [AW-1:0] cur_k_reg;
    logic [PW-1:0] cur_l_reg;
    logic [PW-1:0] cur_r_reg;

    logic [AW-1:0] stk_k [rast_pkg::STK_DEPTH];
    logic [PW-1:0] stk_l [rast_pkg::STK_DEPTH];
    logic [PW-1:0] stk_r [rast_pkg::STK_DEPTH];
    logic          stk_ph [rast_pkg::STK_DEPTH];

    logic [AW-1:0]    na_k_reg;
    logic [SW-1:0]    na_v_reg;
    logic [PW-1:0]    na_len_reg;
    logic [4:0]       na_ret_reg;
    logic [SW-1:0]    sum_q_reg;
    logic [SW-1:0]    pend_q_reg;
    logic [VW+PW-1:0] prod_lo_reg;
    logic [VW-1:0]    prod_hi_reg;
    logic [SW-1:0]    part_reg;
    logic [SW-1:0]    a_reg;
    logic [SW-1:0]    acc_reg;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          sum_we;
    logic          pend_we;
    logic [SW-1:0] sum_wd;
    logic [SW-1:0] pend_wd;
    logic [SW-1:0] rd_sum;
    logic [SW-1:0] rd_pend;

    logic [PW:0]      mid_full;
    logic [PW-1:0]    mid;
    logic             covered;
    logic [AW-1:0]    child_l;
    logic [AW-1:0]    child_r;
    logic [VW-1:0]    mul_a;
    logic [VW+PW-1:0] mul_p;
    logic [SPW-1:0]   sp_top;

    assign mid_full = {1'b0, cur_l_reg} + {1'b0, cur_r_reg};
    assign mid      = mid_full[PW:1];
    assign covered  = (req_reg.lo <= cur_l_reg) && (req_reg.hi >= cur_r_reg);
    assign child_l  = {cur_k_reg[AW-2:0], 1'b0};
    assign child_r  = {cur_k_reg[AW-2:0], 1'b1};
    assign mul_a    = (state_reg == S_NA_M0) ? na_v_reg[VW-1:0] : na_v_reg[SW-1:VW];
    assign mul_p    = mul_a * na_len_reg;
    assign sp_top   = sp_reg - SPW'(1);

    always_comb begin
        rd_addr = cur_k_reg;
        wr_addr = cur_k_reg;
        sum_we  = 1'b0;
        pend_we = 1'b0;
        sum_wd  = '0;
        pend_wd = '0;
        unique case (state_reg)
            S_NA_RD: rd_addr = na_k_reg;
            S_FIX:   rd_addr = child_l;
            S_F_RD1: rd_addr = child_r;
            default: rd_addr = cur_k_reg;
        endcase
        unique case (state_reg)
            S_CLEAR: begin
                wr_addr = clr_cnt_reg;
                sum_we  = 1'b1;
                pend_we = 1'b1;
            end
            S_NA_WR: begin
                wr_addr = na_k_reg;
                sum_we  = 1'b1;
                pend_we = 1'b1;
                sum_wd  = part_reg + {prod_hi_reg, {VW{1'b0}}};
                pend_wd = pend_q_reg + na_v_reg;
            end
            S_P_CLR: begin
                pend_we = 1'b1;
            end
            S_F_WR: begin
                sum_we = 1'b1;
                sum_wd = a_reg + rd_sum;
            end
            default: begin
                sum_we = 1'b0;
            end
        endcase
    end

    rast_ram #(.WIDTH(SW), .DEPTH(rast_pkg::NODE_DEPTH), .AW(AW)) u_sum_ram (
        .aclk    (aclk),
        .wr_en   (sum_we),
        .wr_addr (wr_addr),
        .wr_data (sum_wd),
        .rd_addr (rd_addr),
        .rd_data (rd_sum)
    );

    rast_ram #(.WIDTH(SW), .DEPTH(rast_pkg::NODE_DEPTH), .AW(AW)) u_pend_ram (
        .aclk    (aclk),
        .wr_en   (pend_we),
        .wr_addr (wr_addr),
        .wr_data (pend_wd),
        .rd_addr (rd_addr),
        .rd_data (rd_pend)
    );

    assign stat.ready = (state_reg == S_IDLE);
    assign stat.done  = (state_reg == S_DONE) && req_reg.is_query && out_free;
    assign result     = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            sp_reg      <= '0;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == {AW{1'b1}}) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        req_reg   <= req;
                        acc_reg   <= '0;
                        sp_reg    <= '0;
                        cur_k_reg <= AW'(1);
                        cur_l_reg <= PW'(1);
                        cur_r_reg <= req.n;
                        state_reg <= (req.lo > req.hi) ? S_DONE : S_ENTER;
                    end
                end
                S_ENTER: begin
                    if (covered) begin
                        if (req_reg.is_query) begin
                            state_reg <= S_Q_ACC;
                        end else begin
                            na_k_reg   <= cur_k_reg;
                            na_v_reg   <= req_reg.val;
                            na_len_reg <= cur_r_reg - cur_l_reg + PW'(1);
                            na_ret_reg <= S_RET;
                            state_reg  <= S_NA_M0;
                        end
                    end else begin
                        state_reg <= S_P_CHK;
                    end
                end
                S_Q_ACC: begin
                    acc_reg   <= acc_reg + rd_sum;
                    state_reg <= S_RET;
                end
                S_P_CHK: begin
                    if (rd_pend == '0) begin
                        state_reg <= S_DESC_L;
                    end else begin
                        na_k_reg   <= child_l;
                        na_v_reg   <= rd_pend;
                        na_len_reg <= mid - cur_l_reg + PW'(1);
                        na_ret_reg <= S_P_R;
                        state_reg  <= S_NA_RD;
                    end
                end
                S_P_R: begin
                    na_k_reg   <= child_r;
                    na_len_reg <= cur_r_reg - mid;
                    na_ret_reg <= S_P_CLR;
                    state_reg  <= S_NA_RD;
                end
                S_P_CLR: begin
                    state_reg <= S_DESC_L;
                end
                S_NA_RD: begin
                    state_reg <= S_NA_M0;
                end
                S_NA_M0: begin
                    sum_q_reg   <= rd_sum;
                    pend_q_reg  <= rd_pend;
                    prod_lo_reg <= mul_p;
                    state_reg   <= S_NA_M1;
                end
                S_NA_M1: begin
                    part_reg    <= sum_q_reg + SW'(prod_lo_reg);
                    prod_hi_reg <= mul_p[VW-1:0];
                    state_reg   <= S_NA_WR;
                end
                S_NA_WR: begin
                    state_reg <= na_ret_reg;
                end
                S_DESC_L: begin
                    if (req_reg.lo <= mid) begin
                        stk_k[sp_reg]  <= cur_k_reg;
                        stk_l[sp_reg]  <= cur_l_reg;
                        stk_r[sp_reg]  <= cur_r_reg;
                        stk_ph[sp_reg] <= PH_LEFT;
                        sp_reg         <= sp_reg + SPW'(1);
                        cur_k_reg      <= child_l;
                        cur_r_reg      <= mid;
                        state_reg      <= S_ENTER;
                    end else begin
                        state_reg <= S_DESC_R;
                    end
                end
                S_DESC_R: begin
                    if (req_reg.hi > mid) begin
                        stk_k[sp_reg]  <= cur_k_reg;
                        stk_l[sp_reg]  <= cur_l_reg;
                        stk_r[sp_reg]  <= cur_r_reg;
                        stk_ph[sp_reg] <= PH_RIGHT;
                        sp_reg         <= sp_reg + SPW'(1);
                        cur_k_reg      <= child_r;
                        cur_l_reg      <= mid + PW'(1);
                        state_reg      <= S_ENTER;
                    end else begin
                        state_reg <= S_FIX;
                    end
                end
                S_FIX: begin
                    state_reg <= req_reg.is_query ? S_RET : S_F_RD1;
                end
                S_F_RD1: begin
                    a_reg     <= rd_sum;
                    state_reg <= S_F_WR;
                end
                S_F_WR: begin
                    state_reg <= S_RET;
                end
                S_RET: begin
                    if (sp_reg == '0) begin
                        state_reg <= S_DONE;
                    end else begin
                        cur_k_reg <= stk_k[sp_top];
                        cur_l_reg <= stk_l[sp_top];
                        cur_r_reg <= stk_r[sp_top];
                        sp_reg    <= sp_top;
                        state_reg <= (stk_ph[sp_top] == PH_LEFT) ? S_DESC_R : S_FIX;
                    end
                end
                S_DONE: begin
                    if (!req_reg.is_query || out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(17))
        else $error("traversal stack too deep");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !(sum_we || pend_we))
        else $error("node write while idle");

    a_node_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ENTER) |-> (cur_l_reg <= cur_r_reg))
        else $error("empty node range visited");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |=> (state_reg == S_IDLE))
        else $error("result handoff did not finish request");

endmodule

/* verif/range_add_range_sum_tree_chk.sv */
`timescale 1ns / 1ps

module range_add_range_sum_tree_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [16:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          errors,
    output int          awaiting
);

    bit [63:0] tree_total [rast_pkg::NODE_DEPTH];
    bit [63:0] tree_lazy  [rast_pkg::NODE_DEPTH];
    bit [16:0] length_reg;
    bit [63:0] expected_sums [$];

    function automatic bit [63:0] total_at(int k);
        return (k < rast_pkg::NODE_DEPTH) ? tree_total[k] : 64'd0;
    endfunction

    function automatic void apply_add(int k, bit [63:0] v, int len);
        if (k >= rast_pkg::NODE_DEPTH) return;
        tree_total[k] += v * 64'(len);
        tree_lazy[k]  += v;
    endfunction

    function automatic void push_lazy(int k, int l, int r);
        bit [63:0] p;
        int mid;
        if (k >= rast_pkg::NODE_DEPTH) return;
        p = tree_lazy[k];
        if (p == 0) return;
        mid = (l + r) >> 1;
        apply_add(2 * k, p, mid - l + 1);
        apply_add(2 * k + 1, p, r - mid);
        tree_lazy[k] = 0;
    endfunction

    function automatic void range_add(int k, int l, int r, int lo, int hi, bit [63:0] v);
        int mid;
        if (lo <= l && hi >= r) begin
            apply_add(k, v, r - l + 1);
            return;
        end
        push_lazy(k, l, r);
        mid = (l + r) >> 1;
        if (lo <= mid) range_add(2 * k, l, mid, lo, hi, v);
        if (hi > mid) range_add(2 * k + 1, mid + 1, r, lo, hi, v);
        if (k < rast_pkg::NODE_DEPTH) tree_total[k] = total_at(2 * k) + total_at(2 * k + 1);
    endfunction

    function automatic bit [63:0] range_sum(int k, int l, int r, int lo, int hi);
        bit [63:0] acc;
        int mid;
        acc = 0;
        if (lo <= l && hi >= r) return total_at(k);
        push_lazy(k, l, r);
        mid = (l + r) >> 1;
        if (lo <= mid) acc += range_sum(2 * k, l, mid, lo, hi);
        if (hi > mid) acc += range_sum(2 * k + 1, mid + 1, r, lo, hi);
        return acc;
    endfunction

    function automatic void predict(bit kind, bit [16:0] left, bit [16:0] right,
                                    bit [31:0] amount);
        int n, lo, hi;
        bit [63:0] v;
        bit [63:0] sum_word;
        n  = length_reg;
        lo = left;
        hi = right;
        v  = {{32{amount[31]}}, amount};
        if (n == 0) n = 1;
        if (n > rast_pkg::MAX_LEAVES) n = rast_pkg::MAX_LEAVES;
        if (lo < 1) lo = 1;
        if (hi > n) hi = n;
        if (kind == rast_pkg::REQ_ADD) begin
            if (lo <= hi) range_add(1, 1, n, lo, hi, v);
        end else begin
            sum_word = (lo <= hi) ? range_sum(1, 1, n, lo, hi) : 64'd0;
            expected_sums.insert(expected_sums.size(), sum_word);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            length_reg = 17'd65536;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_sums.size() == 0) begin
                    $error("unexpected range_sum word: %0d", $signed(m_tdata));
                    errors++;
                end else begin
                    if (m_tdata !== expected_sums[0]) begin
                        $error("range_sum mismatch: expected %0d actual %0d",
                               $signed(expected_sums[0]), $signed(m_tdata));
                        errors++;
                    end
                    void'(expected_sums.pop_front());
                end
            end
            if (s_tvalid && s_tready)
                predict(s_tuser, s_tdata[16:0], s_tdata[33:17], s_tdata[65:34]);
            if (cfg_wen) length_reg = cfg_wdata;
            awaiting <= expected_sums.size();
        end
    end
endmodule

/* verif/range_add_range_sum_tree_tb.sv */
`timescale 1ns / 1ps

module range_add_range_sum_tree_tb;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wen;
    logic [16:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    int          errors;
    int          awaiting;

    bit          idle_on;
    bit          hold_req;
    int          cur_len;

    range_add_range_sum_tree dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    range_add_range_sum_tree_chk chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .awaiting(awaiting)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #120ms;
        $display("range_add_range_sum_tree_tb failed");
        $finish;
    end

    // receiver side
    initial begin
        m_tready = 0;
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_tready = 0;
                repeat (4000) @(negedge aclk);
                hold_req = 0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                m_tready = 0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end else begin
                m_tready = 1;
                @(negedge aclk);
            end
        end
    end

    task automatic send_word(bit kind, bit [16:0] left, bit [16:0] right, bit [31:0] amount);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser  = kind;
        s_tdata  = {6'd0, amount, right, left};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic write_length(bit [16:0] len);
        while (awaiting != 0 || !s_tready) @(negedge aclk);
        repeat (700) @(negedge aclk);
        cfg_wen   = 1;
        cfg_wdata = len;
        @(negedge aclk);
        cfg_wen = 0;
        cur_len = (len == 0) ? 1 : (len > 65536) ? 65536 : len;
    endtask

    task automatic random_word();
        bit [16:0] a, b, t;
        bit [31:0] v;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
            a = 17'($urandom_range(1, cur_len));
            b = 17'($urandom_range(1, cur_len));
            if (a > b) begin
                t = a; a = b; b = t;
            end
        end else if (sel < 88) begin
            a = 17'($urandom_range(0, cur_len + 2));
            b = 17'($urandom_range(0, cur_len + 2));
        end else begin
            a = 17'($urandom);
            b = 17'($urandom);
        end
        v = ($urandom_range(0, 2) == 0) ? $urandom : 32'($signed($urandom_range(0, 200)) - 100);
        send_word(1'($urandom_range(0, 1)), a, b, v);
    endtask

    int lengths [8] = '{1, 2, 0, 5, 37, 1000, 131071, 65536};

    initial begin
        aresetn   = 0;
        cfg_wen   = 0;
        cfg_wdata = 0;
        s_tvalid  = 0;
        s_tdata   = 0;
        s_tuser   = 0;
        idle_on   = 1;
        hold_req  = 0;
        cur_len   = 65536;
        repeat (6) @(negedge aclk);
        aresetn = 1;

        send_word(rast_pkg::REQ_ADD, 1, 65536, 32'h7fffffff);
        send_word(rast_pkg::REQ_ADD, 1, 1, 32'h80000000);
        send_word(rast_pkg::REQ_SUM, 1, 65536, 0);
        send_word(rast_pkg::REQ_SUM, 0, 17'h1ffff, 32'hffffffff);
        send_word(rast_pkg::REQ_SUM, 65536, 65536, 0);
        send_word(rast_pkg::REQ_ADD, 5, 3, 32'h12345678);
        send_word(rast_pkg::REQ_SUM, 5, 3, 0);
        send_word(rast_pkg::REQ_ADD, 70000, 80000, 32'h55555555);
        send_word(rast_pkg::REQ_SUM, 70000, 17'h1ffff, 0);
        send_word(rast_pkg::REQ_ADD, 1, 0, 32'haaaaaaaa);
        send_word(rast_pkg::REQ_SUM, 0, 0, 0);
        send_word(rast_pkg::REQ_ADD, 32768, 32769, 32'hffffffff);
        send_word(rast_pkg::REQ_SUM, 32767, 32770, 0);
        send_word(rast_pkg::REQ_ADD, 100, 200, 32'd7);
        send_word(rast_pkg::REQ_SUM, 150, 150, 0);
        send_word(rast_pkg::REQ_SUM, 1, 1, 0);
        send_word(rast_pkg::REQ_SUM, 99, 201, 0);

        foreach (lengths[i]) begin
            write_length(17'(lengths[i]));
            if (lengths[i] == 37) hold_req = 1;
            if (i == 7) begin
                for (int j = 0; j < 190; j++) begin
                    if (j == 120) idle_on = 0;
                    random_word();
                end
            end else begin
                repeat (185) random_word();
            end
        end

        while (awaiting != 0) @(negedge aclk);
        repeat (700) @(negedge aclk);
        if (errors == 0) begin
            $display("range_add_range_sum_tree_tb passed");
        end else begin
            $display("range_add_range_sum_tree_tb failed");
        end
        $finish;
    end
endmodule
